FILE: rtl/servo_cubic_trajectory_pi_top_assert.svh
// ---------------------------------------------------------------------------
// Servo trajectory PI controller: assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SERVO_CUBIC_TRAJECTORY_PI_TOP_ASSERT_SVH
`define SERVO_CUBIC_TRAJECTORY_PI_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property holds at every edge outside reset
`define SRVPI_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("srvpi: assertion failed");

// consequence holds in the cycle after the trigger
`define SRVPI_ASSERT_NEXT(name, trig, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
	else $error("srvpi: assertion failed");

`else

`define SRVPI_ASSERT(name, prop)
`define SRVPI_ASSERT_NEXT(name, trig, cons)

`endif

`endif

FILE: rtl/srvpi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo trajectory PI controller: package
// Shared widths, reset values, limits and codes.
// ---------------------------------------------------------------------------
package srvpi_pkg;

	// default sizing
	localparam int MOTORS_DEF        = 6;
	localparam int POSITION_BITS_DEF = 10;

	// fixed field widths
	localparam int MOTOR_W   = 3;
	localparam int DUR_W     = 16;
	localparam int TIME_W    = 32;
	localparam int GAIN_W    = 8;
	localparam int MAG_W     = 15;
	localparam int CFG_IDX_W = 3;

	// quotient of e * 2^16 / d with e <= d: 0..65536
	localparam int QUO_W = DUR_W + 1;

	// shared multiplier operand widths (signed)
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// PI arithmetic widths
	localparam int INTEG_W = 11;
	localparam int ACC_W   = 24;
	localparam int DRIVE_W = 16;

	localparam int INTEG_LIMIT = 1000;
	localparam int DRIVE_LIMIT = 32767;

	// register reset values
	localparam int PROP_GAIN_RST  = 1;
	localparam int INTEG_GAIN_RST = 0;
	localparam int REV_MASK_RST   = 40;
	localparam int MIN_POS_RST    = 100;
	localparam int MAX_POS_RST    = 960;

	// opcodes
	localparam logic OP_MOVE   = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_REV_MASK   = 3'd2,
		REG_MIN_POS    = 3'd3,
		REG_MAX_POS    = 3'd4
	} srvpi_reg_t;

endpackage

FILE: rtl/srvpi_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed 32 x 18 multiply with a registered product.
// ---------------------------------------------------------------------------
module srvpi_mul (
	input  logic                                 clk,
	input  logic signed [srvpi_pkg::MUL_A_W-1:0] mul_a,
	input  logic signed [srvpi_pkg::MUL_B_W-1:0] mul_b,
	output logic signed [srvpi_pkg::MUL_P_W-1:0] mul_p
);
	import srvpi_pkg::*;

	logic signed [MUL_P_W-1:0] prod_q;

	// product register
	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
	end

	assign mul_p = prod_q;

endmodule

FILE: rtl/srvpi_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial divider
// Restoring division of e * 2^16 by d for e <= d, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module srvpi_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [srvpi_pkg::DUR_W-1:0]   dividend,
	input  logic [srvpi_pkg::DUR_W-1:0]   divisor,
	output logic                          done,
	output logic [srvpi_pkg::QUO_W-1:0]   quotient
);
	import srvpi_pkg::*;

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DUR_W:0]   rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic             ge;
	logic [DUR_W:0]   rem_nx;

	// trial subtract
	assign ge     = (rem_q >= {1'b0, divisor});
	assign rem_nx = ge ? (rem_q - {1'b0, divisor}) : rem_q;

	// first step yields the 2^16 bit, then 16 steps shifting in zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= {1'b0, dividend};
				quo_q <= '0;
				cnt_q <= CNT_W'(QUO_W);
			end else if (cnt_q != '0) begin
				rem_q <= {rem_nx[DUR_W-1:0], 1'b0};
				quo_q <= {quo_q[QUO_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/servo_cubic_trajectory_pi_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo cubic trajectory PI controller
// Per-motor cubic in-out set point easing with shared-gain PI control.
// ---------------------------------------------------------------------------
//  channel  | handshake              | word
//  ---------+------------------------+---------------------------------------
//  cfg      | cfg_wen                | cfg_index, cfg_data
//  in       | in_valid / in_ready    | opcode, motor, goal, duration, time,
//           |                        | position sample
//  out      | out_valid / out_ready  | drive_motor, magnitude, reverse,
//           |                        | set_point
//
//  A move command stores its goal, start, time and duration. An update
//  starts the serial divider, waits while it forms t/d (17 quotient bits
//  and a done flag), then takes ten steps through the one shared multiplier,
//  the PI adders and the output register. A zero duration skips the divider and the easing steps.
//  Reset clears the registers to defaults and all motor state to zero.
//  in_ready is high only while the sequencer is idle; a finished result
//  waits in the output register while the next word is taken, and the last
//  step stalls while an earlier word there is still unread.
// ---------------------------------------------------------------------------
`include "servo_cubic_trajectory_pi_top_assert.svh"

module servo_cubic_trajectory_pi_top #(
	parameter int MOTORS        = srvpi_pkg::MOTORS_DEF,
	parameter int POSITION_BITS = srvpi_pkg::POSITION_BITS_DEF,
	parameter int CFG_W = (POSITION_BITS > srvpi_pkg::GAIN_W) ?
		((POSITION_BITS > MOTORS) ? POSITION_BITS : MOTORS) :
		((srvpi_pkg::GAIN_W > MOTORS) ? srvpi_pkg::GAIN_W : MOTORS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_wen,
	input  logic [srvpi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]                  cfg_data,
	// input words
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [srvpi_pkg::MOTOR_W-1:0]     motor,
	input  logic [POSITION_BITS-1:0]          goal_position,
	input  logic [srvpi_pkg::DUR_W-1:0]       move_ticks,
	input  logic [srvpi_pkg::TIME_W-1:0]      time_now,
	input  logic [POSITION_BITS-1:0]          position_sample,
	// result words
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [srvpi_pkg::MOTOR_W-1:0]     drive_motor,
	output logic [srvpi_pkg::MAG_W-1:0]       drive_magnitude,
	output logic                              drive_reverse,
	output logic [POSITION_BITS-1:0]          set_point
);
	import srvpi_pkg::*;

	localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam int MCNT_W = MOTOR_W + 2;
	localparam int PB     = POSITION_BITS;
	localparam int NUM_W  = PB + 18;

	localparam logic [MCNT_W-1:0]        MOTOR_CNT = MCNT_W'(MOTORS);
	localparam logic signed [ACC_W-1:0]  INTEG_HI  = ACC_W'(INTEG_LIMIT);
	localparam logic signed [ACC_W-1:0]  INTEG_LO  = ACC_W'(-INTEG_LIMIT);
	localparam logic signed [ACC_W-1:0]  DRIVE_HI  = ACC_W'(DRIVE_LIMIT);
	localparam logic signed [ACC_W-1:0]  DRIVE_LO  = ACC_W'(-DRIVE_LIMIT);
	localparam logic signed [INTEG_W-1:0] INTEG_HI_S = INTEG_W'(INTEG_LIMIT);
	localparam logic signed [INTEG_W-1:0] INTEG_LO_S = INTEG_W'(-INTEG_LIMIT);
	localparam logic [QUO_W-1:0]         ONE_Q16   = QUO_W'(65536);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOVE,
		S_TRAJ,
		S_DIV,
		S_SQ,
		S_CUBE,
		S_EASE,
		S_LERP,
		S_SP,
		S_ERR,
		S_IMUL,
		S_INTEG,
		S_DRIVE,
		S_OUT
	} state_t;

	// configuration registers
	logic [GAIN_W-1:0] prop_gain_q;
	logic [GAIN_W-1:0] integ_gain_q;
	logic [MOTORS-1:0] rev_mask_q;
	logic [PB-1:0]     min_pos_q;
	logic [PB-1:0]     max_pos_q;

	// per-motor state
	logic [PB-1:0]               fin_q   [MOTORS];
	logic [PB-1:0]               start_q [MOTORS];
	logic [PB-1:0]               cur_sp_q[MOTORS];
	logic [TIME_W-1:0]           req_q   [MOTORS];
	logic [DUR_W-1:0]            dur_st_q[MOTORS];
	logic signed [INTEG_W-1:0]   isum_q  [MOTORS];

	// sequencer and latched word
	state_t                    state_q;
	logic [MOTOR_W-1:0]        motor_q;
	logic [PB-1:0]             goal_q;
	logic [DUR_W-1:0]          dur_q;
	logic [TIME_W-1:0]         now_q;
	logic [PB-1:0]             sample_q;

	// working registers
	logic                      half_q;
	logic [DUR_W-1:0]          w_q;
	logic [QUO_W-1:0]          f_q;
	logic [PB-1:0]             sp_q;
	logic signed [PB:0]        err_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [DRIVE_W-1:0] drive_q;

	// output register
	logic                      out_valid_q;
	logic [MOTOR_W-1:0]        out_motor_q;
	logic [MAG_W-1:0]          out_mag_q;
	logic                      out_rev_q;
	logic [PB-1:0]             out_sp_q;

	// datapath wires
	logic [MIDX_W-1:0]         midx;
	logic [TIME_W-1:0]         elapsed;
	logic [DUR_W-1:0]          e_clamp;
	logic                      div_start;
	logic                      div_done;
	logic [QUO_W-1:0]          div_quo;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic signed [PB:0]        diff;
	logic [DUR_W-1:0]          cube;
	logic signed [NUM_W-1:0]   num;
	logic signed [ACC_W-1:0]   integ_sum;
	logic signed [ACC_W-1:0]   drive_sum;
	logic [PB-1:0]             goal_clamp;
	logic [DRIVE_W-1:0]        mag_full;
	logic                      rev_bit;
	logic                      out_load;

	assign midx = MIDX_W'(motor_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= GAIN_W'(PROP_GAIN_RST);
			integ_gain_q <= GAIN_W'(INTEG_GAIN_RST);
			rev_mask_q   <= MOTORS'(REV_MASK_RST);
			min_pos_q    <= PB'(MIN_POS_RST);
			max_pos_q    <= PB'(MAX_POS_RST);
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN: integ_gain_q <= cfg_data[GAIN_W-1:0];
				REG_REV_MASK:   rev_mask_q   <= cfg_data[MOTORS-1:0];
				REG_MIN_POS:    min_pos_q    <= cfg_data[PB-1:0];
				REG_MAX_POS:    max_pos_q    <= cfg_data[PB-1:0];
				default: ;
			endcase
		end
	end

	// goal limits: the maximum is tested first, then the minimum
	always_comb begin
		if (goal_q > max_pos_q) begin
			goal_clamp = max_pos_q;
		end else if (goal_q < min_pos_q) begin
			goal_clamp = min_pos_q;
		end else begin
			goal_clamp = goal_q;
		end
	end

	// elapsed time, negative held to 0, beyond duration held to d
	assign elapsed = now_q - req_q[midx];
	always_comb begin
		if (elapsed[TIME_W-1]) begin
			e_clamp = '0;
		end else if (elapsed > TIME_W'(dur_st_q[midx])) begin
			e_clamp = dur_st_q[midx];
		end else begin
			e_clamp = elapsed[DUR_W-1:0];
		end
	end

	assign div_start = (state_q == S_TRAJ) && (dur_st_q[midx] != '0);

	srvpi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (e_clamp),
		.divisor  (dur_st_q[midx]),
		.done     (div_done),
		.quotient (div_quo)
	);

	// move span, goal minus start
	assign diff = $signed({1'b0, fin_q[midx]}) - $signed({1'b0, start_q[midx]});

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				mul_a = $signed(MUL_A_W'(w_q));
				mul_b = $signed(MUL_B_W'(w_q));
			end
			S_CUBE: begin
				mul_a = $signed({1'b0, mul_p[MUL_A_W-2:0]});
				mul_b = $signed(MUL_B_W'(w_q));
			end
			S_LERP: begin
				mul_a = MUL_A_W'(diff);
				mul_b = $signed(MUL_B_W'(f_q));
			end
			S_IMUL: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = $signed(MUL_B_W'(integ_gain_q));
			end
			S_INTEG: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = $signed(MUL_B_W'(prop_gain_q));
			end
			default: ;
		endcase
	end

	srvpi_mul u_mul (
		.clk   (clk),
		.mul_a (mul_a),
		.mul_b (mul_b),
		.mul_p (mul_p)
	);

	// cube in Q16 after the 2^30 scale
	assign cube = mul_p[DUR_W+29:30];

	// start in Q16 plus span times ease fraction
	assign num = $signed({2'b00, start_q[midx], 16'h0000}) + NUM_W'(mul_p);

	// integral and drive sums
	assign integ_sum = ACC_W'(isum_q[midx]) + ACC_W'(mul_p);
	assign drive_sum = ACC_W'(mul_p) + ACC_W'(integ_q);

	// magnitude and direction
	assign mag_full = drive_q[DRIVE_W-1] ? DRIVE_W'(-drive_q) : drive_q;
	assign rev_bit  = rev_mask_q[midx] ? (drive_q > 0) : drive_q[DRIVE_W-1];

	// result goes into the output register once it is free
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			motor_q     <= '0;
			goal_q      <= '0;
			dur_q       <= '0;
			now_q       <= '0;
			sample_q    <= '0;
			half_q      <= 1'b0;
			w_q         <= '0;
			f_q         <= '0;
			sp_q        <= '0;
			err_q       <= '0;
			integ_q     <= '0;
			drive_q     <= '0;
			out_valid_q <= 1'b0;
			out_motor_q <= '0;
			out_mag_q   <= '0;
			out_rev_q   <= 1'b0;
			out_sp_q    <= '0;
			for (int m = 0; m < MOTORS; m++) begin
				fin_q[m]    <= '0;
				start_q[m]  <= '0;
				cur_sp_q[m] <= '0;
				req_q[m]    <= '0;
				dur_st_q[m] <= '0;
				isum_q[m]   <= '0;
			end
		end else begin
			// output word flag
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						motor_q  <= motor;
						goal_q   <= goal_position;
						dur_q    <= move_ticks;
						now_q    <= time_now;
						sample_q <= position_sample;
						// words for absent motors are dropped
						if ({2'b00, motor} < MOTOR_CNT) begin
							state_q <= (opcode == OP_MOVE) ? S_MOVE : S_TRAJ;
						end
					end
				end
				S_MOVE: begin
					fin_q[midx]    <= goal_clamp;
					start_q[midx]  <= cur_sp_q[midx];
					req_q[midx]    <= now_q;
					dur_st_q[midx] <= dur_q;
					state_q        <= S_IDLE;
				end
				S_TRAJ: begin
					// zero duration jumps to the goal
					if (dur_st_q[midx] == '0) begin
						sp_q    <= fin_q[midx];
						state_q <= S_ERR;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						half_q  <= (div_quo[QUO_W-1:QUO_W-2] != 2'b00);
						w_q     <= (div_quo[QUO_W-1:QUO_W-2] != 2'b00) ?
							DUR_W'(ONE_Q16 - div_quo) : div_quo[DUR_W-1:0];
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					state_q <= S_CUBE;
				end
				S_CUBE: begin
					state_q <= S_EASE;
				end
				S_EASE: begin
					f_q     <= half_q ? (ONE_Q16 - QUO_W'(cube)) : QUO_W'(cube);
					state_q <= S_LERP;
				end
				S_LERP: begin
					state_q <= S_SP;
				end
				S_SP: begin
					sp_q    <= num[PB+15:16];
					state_q <= S_ERR;
				end
				S_ERR: begin
					err_q          <= $signed({1'b0, sample_q}) - $signed({1'b0, sp_q});
					cur_sp_q[midx] <= sp_q;
					state_q        <= S_IMUL;
				end
				S_IMUL: begin
					state_q <= S_INTEG;
				end
				S_INTEG: begin
					// anti-windup clamp
					if (integ_sum > INTEG_HI) begin
						integ_q      <= INTEG_HI_S;
						isum_q[midx] <= INTEG_HI_S;
					end else if (integ_sum < INTEG_LO) begin
						integ_q      <= INTEG_LO_S;
						isum_q[midx] <= INTEG_LO_S;
					end else begin
						integ_q      <= integ_sum[INTEG_W-1:0];
						isum_q[midx] <= integ_sum[INTEG_W-1:0];
					end
					state_q <= S_DRIVE;
				end
				S_DRIVE: begin
					if (drive_sum > DRIVE_HI) begin
						drive_q <= DRIVE_W'(DRIVE_HI);
					end else if (drive_sum < DRIVE_LO) begin
						drive_q <= DRIVE_W'(DRIVE_LO);
					end else begin
						drive_q <= drive_sum[DRIVE_W-1:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free
					if (out_load) begin
						out_motor_q <= motor_q;
						out_mag_q   <= mag_full[MAG_W-1:0];
						out_rev_q   <= rev_bit;
						out_sp_q    <= sp_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign drive_motor     = out_motor_q;
	assign drive_magnitude = out_mag_q;
	assign drive_reverse   = out_rev_q;
	assign set_point       = out_sp_q;

	// checks
	`SRVPI_ASSERT(a_integ_range, (state_q == S_DRIVE) |-> ((integ_q <= INTEG_HI_S) && (integ_q >= INTEG_LO_S)))
	`SRVPI_ASSERT(a_div_owner, div_done |-> (state_q == S_DIV))
	`SRVPI_ASSERT(a_sp_between, (state_q == S_ERR) |-> (((sp_q <= fin_q[midx]) || (sp_q <= start_q[midx])) && ((sp_q >= fin_q[midx]) || (sp_q >= start_q[midx]))))
	`SRVPI_ASSERT_NEXT(a_out_load, (!out_valid_q && (state_q != S_OUT)), !out_valid_q)
	`SRVPI_ASSERT(a_zero_fwd, (out_valid_q && (out_mag_q == '0)) |-> !out_rev_q)

endmodule
